// ----- rtl/mbrgb_pkg.sv -----
// Shared constants and types for the macroblock YCbCr 4:2:0 to RGB converter.
package mbrgb_pkg;

    localparam int SAMPLE_WIDTH_DEF = 11;

    localparam int COEF_W        = 14;
    localparam int COEF_RED_CR   = 5742;
    localparam int COEF_GREEN_CB = -1407;
    localparam int COEF_GREEN_CR = -2925;
    localparam int COEF_BLUE_CB  = 7258;
    localparam int FRAC_BITS     = 12;
    localparam int LUMA_OFFSET   = 128;

    localparam int MB_SAMPLES     = 384;
    localparam int CHROMA_SAMPLES = 128;
    localparam int COUNT_W        = 9;
    localparam int CHROMA_ADDR_W  = 6;
    localparam int PIX_W          = 8;
    localparam int COORD_W        = 4;
    localparam int OUT_DATA_W     = 3 * PIX_W + 2 * COORD_W;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } pix_pos_t;

endpackage

// ----- rtl/mbrgb_chroma_mem.sv -----
// Cb and Cr sample memories, one write port and one registered read port each.
module mbrgb_chroma_mem
    import mbrgb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic                            wr_cr,
    input  logic [CHROMA_ADDR_W-1:0]        wr_addr,
    input  logic signed [SAMPLE_WIDTH-1:0]  wr_data,
    input  logic                            rd_en,
    input  logic [CHROMA_ADDR_W-1:0]        rd_addr,
    output logic signed [SAMPLE_WIDTH-1:0]  cb,
    output logic signed [SAMPLE_WIDTH-1:0]  cr
);

    localparam int DEPTH = 1 << CHROMA_ADDR_W;

    logic signed [SAMPLE_WIDTH-1:0] cb_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] cr_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_cr)
        begin
            cb_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            cb <= cb_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_cr)
        begin
            cr_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            cr <= cr_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/mbrgb_color_pipe.sv -----
// Color matrix: chroma scaling stage, then sum, clamp and output register.
module mbrgb_color_pipe
    import mbrgb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  cb,
    input  logic signed [SAMPLE_WIDTH-1:0]  cr,
    input  logic signed [SAMPLE_WIDTH:0]    y,
    input  pix_pos_t                        pos,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_DATA_W-1:0]           m_axis_tdata,  // red, green, blue, column, row
    output logic                            m_axis_tlast   // last_pixel
);

    localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
    localparam int SCALE_W = PROD_W - FRAC_BITS;
    localparam int Y_W     = SAMPLE_WIDTH + 1;
    localparam int SUM_W   = SAMPLE_WIDTH + 4;

    localparam logic signed [COEF_W-1:0] K_RC = COEF_W'(COEF_RED_CR);
    localparam logic signed [COEF_W-1:0] K_GB = COEF_W'(COEF_GREEN_CB);
    localparam logic signed [COEF_W-1:0] K_GR = COEF_W'(COEF_GREEN_CR);
    localparam logic signed [COEF_W-1:0] K_BB = COEF_W'(COEF_BLUE_CB);

    logic signed [PROD_W-1:0]  p_rc, p_gb, p_gr, p_bb;
    logic signed [SCALE_W-1:0] s_rc_reg, s_gb_reg, s_gr_reg, s_bb_reg;
    logic signed [Y_W-1:0]     y2_reg;
    pix_pos_t                  pos2_reg;
    logic                      v2_reg;
    logic                      en2, en3;

    logic signed [SUM_W-1:0]   sum_r, sum_g, sum_b;
    logic [PIX_W-1:0]          red_next, green_next, blue_next;
    logic [PIX_W-1:0]          red_reg, green_reg, blue_reg;
    pix_pos_t                  pos3_reg;
    logic                      v3_reg;

    function automatic logic [PIX_W-1:0] clamp8(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > SUM_W'(255))
        begin
            res = '1;
        end
        else
        begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    assign en3      = !v3_reg || m_axis_tready;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    assign p_rc = PROD_W'(cr) * PROD_W'(K_RC);
    assign p_gb = PROD_W'(cb) * PROD_W'(K_GB);
    assign p_gr = PROD_W'(cr) * PROD_W'(K_GR);
    assign p_bb = PROD_W'(cb) * PROD_W'(K_BB);

    // floor(product / 2^12) is the upper slice
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s_rc_reg <= p_rc[PROD_W-1:FRAC_BITS];
            s_gb_reg <= p_gb[PROD_W-1:FRAC_BITS];
            s_gr_reg <= p_gr[PROD_W-1:FRAC_BITS];
            s_bb_reg <= p_bb[PROD_W-1:FRAC_BITS];
            y2_reg   <= y;
            pos2_reg <= pos;
        end
    end

    assign sum_r = SUM_W'(y2_reg) + SUM_W'(s_rc_reg);
    assign sum_g = SUM_W'(y2_reg) + SUM_W'(s_gb_reg) + SUM_W'(s_gr_reg);
    assign sum_b = SUM_W'(y2_reg) + SUM_W'(s_bb_reg);

    assign red_next   = clamp8(sum_r);
    assign green_next = clamp8(sum_g);
    assign blue_next  = clamp8(sum_b);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            pos3_reg  <= pos2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= in_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {pos3_reg.row, pos3_reg.col, blue_reg, green_reg, red_reg};
    assign m_axis_tlast  = pos3_reg.last;

endmodule

// ----- rtl/macroblock_ycbcr420_to_rgb_unit.sv -----
// Top level of the macroblock YCbCr 4:2:0 to RGB converter.
//
// Input stream s_axis: one signed sample per beat in macroblock order,
// 64 Cb, 64 Cr, then four 8x8 luma blocks (TL, TR, BL, BR), raster order.
// Chroma beats are written to the Cb/Cr memories and give no output.
// Output stream m_axis: one pixel per luma beat, RGB plus row and column;
// tlast marks the pixel of the 384th sample of the macroblock.
// Throughput: one beat per cycle on both sides while m_axis does not
// stall. A luma beat that is taken passes the memory read, the scaling
// multiply and the sum/clamp output register before it shows on m_axis.
// Reset clears the sample position and empties the pipeline; memory
// contents are not cleared, every entry is written before it is read.
// When m_axis stalls, the pipeline stages fill up one by one; s_axis
// tready drops only once every stage holds a pixel.
module macroblock_ycbcr420_to_rgb_unit
    import mbrgb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]                  m_axis_tdata,  // red, green, blue, column, row
    output logic                                   m_axis_tlast   // last_pixel
);

    logic [COUNT_W-1:0]             cnt_reg, cnt_next;
    logic                           s_fire, is_chroma, is_last;
    logic [COUNT_W-1:0]             luma_pos;
    pix_pos_t                       pos_next, pos1_reg;
    logic [CHROMA_ADDR_W-1:0]       rd_addr;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH:0]   y_next, y1_reg;
    logic                           v1_reg, en1, pipe_ready;
    logic signed [SAMPLE_WIDTH-1:0] cb, cr;

    assign sample    = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign is_chroma = cnt_reg < COUNT_W'(CHROMA_SAMPLES);
    assign is_last   = cnt_reg == COUNT_W'(MB_SAMPLES - 1);
    assign luma_pos  = cnt_reg - COUNT_W'(CHROMA_SAMPLES);
    assign cnt_next  = is_last ? '0 : cnt_reg + 1'b1;

    // luma_pos: [7:6] block, [5:3] row in block, [2:0] column in block
    assign pos_next.row  = {luma_pos[7], luma_pos[5:3]};
    assign pos_next.col  = {luma_pos[6], luma_pos[2:0]};
    assign pos_next.last = is_last;
    assign rd_addr       = {pos_next.row[3:1], pos_next.col[3:1]};

    assign y_next = (SAMPLE_WIDTH + 1)'(sample) + (SAMPLE_WIDTH + 1)'(LUMA_OFFSET);

    assign en1           = !v1_reg || pipe_ready;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                cnt_reg <= cnt_next;
            end
            if (en1)
            begin
                v1_reg <= s_fire && !is_chroma;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            y1_reg   <= y_next;
            pos1_reg <= pos_next;
        end
    end

    mbrgb_chroma_mem #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_chroma_mem (
        .clk     (clk),
        .wr_en   (s_fire && is_chroma),
        .wr_cr   (cnt_reg[CHROMA_ADDR_W]),
        .wr_addr (cnt_reg[CHROMA_ADDR_W-1:0]),
        .wr_data (sample),
        .rd_en   (en1),
        .rd_addr (rd_addr),
        .cb      (cb),
        .cr      (cr)
    );

    mbrgb_color_pipe #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_color_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (v1_reg),
        .in_ready      (pipe_ready),
        .cb            (cb),
        .cr            (cr),
        .y             (y1_reg),
        .pos           (pos1_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- tb/mbrgb_tb_pkg.sv -----
`timescale 1ns / 1ps
// Pixel predictor and scoreboard for the macroblock YCbCr 4:2:0 to RGB converter testbench.
package mbrgb_tb_pkg;
    import mbrgb_pkg::*;

    localparam int SW   = SAMPLE_WIDTH_DEF;
    localparam int IN_W = ((SW + 7) / 8) * 8;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_pixel;
    } pixel_t;

    class pixel_scoreboard;
        int     chroma_mem[CHROMA_SAMPLES];
        int     position;
        pixel_t pending_pixels[$];
        int     errors;
        int     pixels_checked;
        int     samples_seen;
        int     clamped_low;
        int     clamped_high;
        int     macroblocks_done;

        function new();
            position         = 0;
            errors           = 0;
            pixels_checked   = 0;
            samples_seen     = 0;
            clamped_low      = 0;
            clamped_high     = 0;
            macroblocks_done = 0;
        endfunction

        function int chroma_term(int c, int coef);
            return (c * coef) >>> FRAC_BITS;
        endfunction

        function logic [PIX_W-1:0] clamp_channel(int v);
            if (v < 0)
            begin
                clamped_low++;
                return '0;
            end
            if (v > 255)
            begin
                clamped_high++;
                return '1;
            end
            return PIX_W'(v);
        endfunction

        // one accepted input beat
        function void note_sample(sample_t s);
            int     pos;
            int     l;
            int     blk;
            int     idx;
            int     rw;
            int     cl;
            int     ci;
            int     cb;
            int     cr;
            int     luma;
            pixel_t px;
            pos = position;
            samples_seen++;
            if (pos < CHROMA_SAMPLES)
            begin
                chroma_mem[pos] = int'(s);
            end
            else
            begin
                l    = pos - CHROMA_SAMPLES;
                blk  = l / 64;
                idx  = l % 64;
                rw   = (blk / 2) * 8 + idx / 8;
                cl   = (blk % 2) * 8 + idx % 8;
                ci   = (rw / 2) * 8 + cl / 2;
                cb   = chroma_mem[ci];
                cr   = chroma_mem[64 + ci];
                luma = int'(s) + LUMA_OFFSET;
                px.red   = clamp_channel(luma + chroma_term(cr, COEF_RED_CR));
                px.green = clamp_channel(luma + chroma_term(cb, COEF_GREEN_CB)
                                         + chroma_term(cr, COEF_GREEN_CR));
                px.blue  = clamp_channel(luma + chroma_term(cb, COEF_BLUE_CB));
                px.column     = COORD_W'(cl);
                px.row        = COORD_W'(rw);
                px.last_pixel = (pos == MB_SAMPLES - 1);
                if (px.last_pixel)
                    macroblocks_done++;
                pending_pixels.push_back(px);
            end
            position = (pos + 1 == MB_SAMPLES) ? 0 : pos + 1;
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= 20)
                $display("MISMATCH at pixel %0d: %s got %0d, want %0d",
                         pixels_checked, what, got, want);
        endtask

        // one accepted output beat
        task check_pixel(logic [OUT_DATA_W-1:0] data, logic last);
            pixel_t want;
            pixels_checked++;
            if (pending_pixels.size() == 0)
            begin
                report("unexpected beat, data", int'(data), 0);
                return;
            end
            want = pending_pixels.pop_front();
            if (data[0 +: PIX_W] !== want.red)
                report("red", data[0 +: PIX_W], want.red);
            if (data[PIX_W +: PIX_W] !== want.green)
                report("green", data[PIX_W +: PIX_W], want.green);
            if (data[2*PIX_W +: PIX_W] !== want.blue)
                report("blue", data[2*PIX_W +: PIX_W], want.blue);
            if (data[3*PIX_W +: COORD_W] !== want.column)
                report("column", data[3*PIX_W +: COORD_W], want.column);
            if (data[3*PIX_W+COORD_W +: COORD_W] !== want.row)
                report("row", data[3*PIX_W+COORD_W +: COORD_W], want.row);
            if (last !== want.last_pixel)
                report("tlast", last, want.last_pixel);
        endtask
    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the macroblock YCbCr 4:2:0 to RGB converter testbench: clock, drivers, monitor.
module tb_top;
    import mbrgb_pkg::*;
    import mbrgb_tb_pkg::*;

    typedef enum int {FILL_CORNER, FILL_FULL, FILL_NATURAL, FILL_MIXED} fill_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int src_idle_pct  = 20;
    int sink_idle_pct = 20;
    int corner_vals[8] = '{-1024, 1023, 0, -1, 1, -128, 127, -512};
    int luma_vals[9]   = '{-1024, 1023, -128, 127, 0, -129, 128, 511, -512};

    pixel_scoreboard sb = new();

    macroblock_ycbcr420_to_rgb_unit #(.SAMPLE_WIDTH(SW)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_200_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int idle_choice(int a, int b);
        case ($urandom_range(2))
            0: return 0;
            1: return a;
            default: return b;
        endcase
    endfunction

    function automatic sample_t pick_sample(fill_t fill, int pos);
        int v;
        case (fill)
            FILL_CORNER:
                if (pos < 64)
                    v = corner_vals[pos % 8];
                else if (pos < CHROMA_SAMPLES)
                    v = corner_vals[((pos - 64) / 8) % 8];
                else
                    v = luma_vals[(pos - CHROMA_SAMPLES) % 9];
            FILL_NATURAL:
                if (pos < CHROMA_SAMPLES)
                    v = int'($urandom_range(400)) - 200;
                else
                    v = int'($urandom_range(320)) - 160;
            FILL_MIXED:
                if ($urandom_range(1) == 0)
                    v = corner_vals[$urandom_range(7)];
                else
                    v = int'($urandom_range(2047)) - 1024;
            default:
                v = int'($urandom_range(2047)) - 1024;
        endcase
        return sample_t'(v);
    endfunction

    task automatic send_sample(sample_t s);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'($unsigned(s));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_sample(s);
    endtask

    task automatic send_macroblock(fill_t fill, int count);
        int pos;
        for (pos = 0; pos < count; pos++)
            send_sample(pick_sample(fill, pos));
    endtask

    // sink side back-pressure
    initial
    begin
        forever
        begin
            if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata, m_axis_tlast);
        end
    end

    initial
    begin
        int mb;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner values: saturation both ways on every channel
        send_macroblock(FILL_CORNER, MB_SAMPLES);

        for (mb = 0; mb < 3; mb++)
        begin
            src_idle_pct  = idle_choice(5, 30);
            sink_idle_pct = idle_choice(10, 40);
            send_macroblock(fill_t'($urandom_range(FILL_FULL, FILL_MIXED)), MB_SAMPLES);
        end

        // no idling, stream ends inside a macroblock
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_macroblock(fill_t'($urandom_range(FILL_FULL, FILL_MIXED)),
                        $urandom_range(CHROMA_SAMPLES + 2, MB_SAMPLES - 1));
        s_axis_tvalid <= 1'b0;

        for (n = 0; n < 4000 && sb.pending_pixels.size() != 0; n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.pending_pixels.size() != 0)
            sb.report("pixels never delivered", 0, sb.pending_pixels.size());

        $display("Sent %0d samples, checked %0d pixels, %0d full macroblocks plus a partial one",
                 sb.samples_seen, sb.pixels_checked, sb.macroblocks_done);
        $display("Channel saturation seen: %0d at zero, %0d at full scale; %0d mismatches",
                 sb.clamped_low, sb.clamped_high, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
